// File: src/min_distance_symbol_detector_unit_macros.svh
`ifndef MIN_DISTANCE_SYMBOL_DETECTOR_UNIT_MACROS_SVH
`define MIN_DISTANCE_SYMBOL_DETECTOR_UNIT_MACROS_SVH

// checked outside reset only
`define MDSD_ASSERT_RUN(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked on every edge, reset included
`define MDSD_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: src/mdsd_pkg.sv
package mdsd_pkg;

  localparam int SAMPLE_WIDTH    = 16;
  localparam int FRACTION_BITS   = 12;
  localparam int SYMBOL_WIDTH    = 4;
  localparam int NUM_POINTS      = 16;
  localparam int ORDER_WIDTH     = 3;
  localparam int FAMILY_WIDTH    = 2;
  localparam int CFG_INDEX_WIDTH = 1;
  localparam int CFG_DATA_WIDTH  = 3;
  localparam int DIFF_WIDTH      = SAMPLE_WIDTH + 1;
  localparam int DIST_WIDTH      = 2 * SAMPLE_WIDTH + 1;

  typedef logic signed [SAMPLE_WIDTH-1:0] coord_t;
  typedef logic signed [DIFF_WIDTH-1:0]   diff_t;
  typedef logic [SAMPLE_WIDTH-1:0]        mag_t;
  typedef logic [2*SAMPLE_WIDTH-1:0]      square_t;
  typedef logic [DIST_WIDTH-1:0]          dist_t;
  typedef logic [SYMBOL_WIDTH-1:0]        symbol_t;
  typedef logic [SYMBOL_WIDTH:0]          count_t;
  typedef logic [ORDER_WIDTH-1:0]         order_t;
  typedef logic [FAMILY_WIDTH-1:0]        family_t;
  typedef logic [CFG_INDEX_WIDTH-1:0]     cfg_index_t;
  typedef logic [CFG_DATA_WIDTH-1:0]      cfg_data_t;

  typedef struct packed {
    logic signed [SAMPLE_WIDTH-1:0] rx_inphase;
    logic signed [SAMPLE_WIDTH-1:0] rx_quadrature;
    logic [SYMBOL_WIDTH-1:0]        sent_symbol;
  } in_word_t;

  typedef struct packed {
    logic [SYMBOL_WIDTH-1:0] decided_symbol;
    logic                    symbol_error;
  } out_word_t;

  typedef struct packed {
    coord_t i;
    coord_t q;
  } point_t;

  typedef enum logic [CFG_INDEX_WIDTH-1:0] {
    REG_MODULATION = 1'b0,
    REG_ORDER_LOG2 = 1'b1
  } cfg_reg_t;

  localparam family_t FAM_PAM = 2'd0;
  localparam family_t FAM_PSK = 2'd1;
  localparam family_t FAM_QAM = 2'd2;

  localparam order_t ORDER_MIN    = 3'd1;
  localparam order_t ORDER_4PT    = 3'd2;
  localparam order_t ORDER_8PT    = 3'd3;
  localparam order_t ORDER_RESET  = 3'd2;
  localparam family_t FAM_RESET   = FAM_QAM;

  typedef enum logic [3:0] {
    CONST_PAM2  = 4'd0,
    CONST_PAM4  = 4'd1,
    CONST_PAM8  = 4'd2,
    CONST_PAM16 = 4'd3,
    CONST_PSK4  = 4'd4,
    CONST_PSK8  = 4'd5,
    CONST_PSK16 = 4'd6,
    CONST_QAM8  = 4'd7,
    CONST_QAM16 = 4'd8
  } const_t;

  localparam int NUM_CONST = 9;

  localparam coord_t ONE  = coord_t'(1 << FRACTION_BITS);
  localparam point_t ZP   = '0;

  // unit rms points in q3.12, unused entries zero
  localparam point_t CONSTELLATION_ROM [NUM_CONST][NUM_POINTS] = '{
    '{0: '{-ONE, 16'sd0}, 1: '{ONE, 16'sd0}, default: ZP},
    '{0: '{-16'sd5495, 16'sd0}, 1: '{-16'sd1832, 16'sd0},
      2: '{16'sd1832, 16'sd0},  3: '{16'sd5495, 16'sd0}, default: ZP},
    '{0: '{-16'sd6257, 16'sd0}, 1: '{-16'sd4469, 16'sd0},
      2: '{-16'sd2681, 16'sd0}, 3: '{-16'sd894, 16'sd0},
      4: '{16'sd894, 16'sd0},   5: '{16'sd2681, 16'sd0},
      6: '{16'sd4469, 16'sd0},  7: '{16'sd6257, 16'sd0}, default: ZP},
    '{0: '{-16'sd6664, 16'sd0},  1: '{-16'sd5776, 16'sd0},
      2: '{-16'sd4887, 16'sd0},  3: '{-16'sd3998, 16'sd0},
      4: '{-16'sd3110, 16'sd0},  5: '{-16'sd2221, 16'sd0},
      6: '{-16'sd1333, 16'sd0},  7: '{-16'sd444, 16'sd0},
      8: '{16'sd444, 16'sd0},    9: '{16'sd1333, 16'sd0},
      10: '{16'sd2221, 16'sd0},  11: '{16'sd3110, 16'sd0},
      12: '{16'sd3998, 16'sd0},  13: '{16'sd4887, 16'sd0},
      14: '{16'sd5776, 16'sd0},  15: '{16'sd6664, 16'sd0}},
    '{0: '{ONE, 16'sd0}, 1: '{16'sd0, ONE},
      2: '{-ONE, 16'sd0}, 3: '{16'sd0, -ONE}, default: ZP},
    '{0: '{ONE, 16'sd0},                1: '{16'sd2896, 16'sd2896},
      2: '{16'sd0, ONE},                3: '{-16'sd2896, 16'sd2896},
      4: '{-ONE, 16'sd0},               5: '{-16'sd2896, -16'sd2896},
      6: '{16'sd0, -ONE},               7: '{16'sd2896, -16'sd2896}, default: ZP},
    '{0: '{ONE, 16'sd0},                 1: '{16'sd3784, 16'sd1567},
      2: '{16'sd2896, 16'sd2896},        3: '{16'sd1567, 16'sd3784},
      4: '{16'sd0, ONE},                 5: '{-16'sd1567, 16'sd3784},
      6: '{-16'sd2896, 16'sd2896},       7: '{-16'sd3784, 16'sd1567},
      8: '{-ONE, 16'sd0},                9: '{-16'sd3784, -16'sd1567},
      10: '{-16'sd2896, -16'sd2896},     11: '{-16'sd1567, -16'sd3784},
      12: '{16'sd0, -ONE},               13: '{16'sd1567, -16'sd3784},
      14: '{16'sd2896, -16'sd2896},      15: '{16'sd3784, -16'sd1567}},
    '{0: '{16'sd5017, 16'sd1672},   1: '{16'sd1672, 16'sd1672},
      2: '{-16'sd1672, 16'sd1672},  3: '{-16'sd5017, 16'sd1672},
      4: '{-16'sd5017, -16'sd1672}, 5: '{-16'sd1672, -16'sd1672},
      6: '{16'sd1672, -16'sd1672},  7: '{16'sd5017, -16'sd1672}, default: ZP},
    '{0: '{-16'sd3886, 16'sd3886},   1: '{-16'sd1295, 16'sd3886},
      2: '{16'sd1295, 16'sd3886},    3: '{16'sd3886, 16'sd3886},
      4: '{16'sd3886, 16'sd1295},    5: '{16'sd1295, 16'sd1295},
      6: '{-16'sd1295, 16'sd1295},   7: '{-16'sd3886, 16'sd1295},
      8: '{-16'sd3886, -16'sd1295},  9: '{-16'sd1295, -16'sd1295},
      10: '{16'sd1295, -16'sd1295},  11: '{16'sd3886, -16'sd1295},
      12: '{16'sd3886, -16'sd3886},  13: '{16'sd1295, -16'sd3886},
      14: '{-16'sd1295, -16'sd3886}, 15: '{-16'sd3886, -16'sd3886}}
  };

endpackage

// File: src/min_distance_symbol_detector_unit.sv
// Hard-decision minimum-distance demapper for PAM, PSK and QAM with 2 to 16 points.
// Input channel (in_valid / in_stall / in_data): one received sample in Q3.12 plus
// the index of the symbol that was sent. Output channel (out_valid / out_stall /
// out_data): index of the nearest constellation point, lowest index on a tie, and
// a flag set when it differs from the sent index.
// Config channel (cfg_valid / cfg_ready / cfg_index / cfg_data): index 0 selects the
// family, index 1 the bits per symbol. cfg_ready is always high; write only while
// no word is in flight.
// After the edge that accepts the input, the word passes the input register, the
// distance register (one 16x16 square per axis for every point), then a 4-level
// compare tree into the output register, where out_valid rises.
// One word per cycle sustained while out_stall is low.
// When out_stall is high the output word holds; the two registers behind it keep
// filling, so in_stall rises only once all three stages hold a word.
// Synchronous reset empties the pipeline and loads the QAM, 4-point selection.
module min_distance_symbol_detector_unit #(
  parameter int MAX_POINTS = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  mdsd_pkg::in_word_t    in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output mdsd_pkg::out_word_t   out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  mdsd_pkg::cfg_index_t  cfg_index,
  input  mdsd_pkg::cfg_data_t   cfg_data
);

  localparam int MAX_ORDER_INT = $clog2(MAX_POINTS + 1) - 1;
  localparam int LANES         = 1 << MAX_ORDER_INT;
  localparam int NODES         = 2 * LANES - 1;
  localparam mdsd_pkg::order_t MAX_ORDER = mdsd_pkg::order_t'(MAX_ORDER_INT);

  mdsd_pkg::family_t  modulation;
  mdsd_pkg::order_t   order_log2;
  mdsd_pkg::order_t   order_eff;
  mdsd_pkg::const_t   sel;
  mdsd_pkg::count_t   point_count;

  logic                 in_reg_valid;
  mdsd_pkg::in_word_t   in_reg;
  logic                 dist_valid;
  mdsd_pkg::dist_t      sq_dist [LANES];
  mdsd_pkg::symbol_t    dist_sent;

  mdsd_pkg::dist_t      sq_dist_next [LANES];
  mdsd_pkg::dist_t      node_d [NODES];
  mdsd_pkg::symbol_t    node_i [NODES];

  logic out_load;
  logic dist_load;
  logic in_load;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      modulation <= mdsd_pkg::FAM_RESET;
      order_log2 <= mdsd_pkg::ORDER_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        mdsd_pkg::REG_MODULATION: modulation <= cfg_data[mdsd_pkg::FAMILY_WIDTH-1:0];
        mdsd_pkg::REG_ORDER_LOG2: order_log2 <= cfg_data;
        default: ;
      endcase
    end
  end

  // effective constellation from the two registers
  always_comb begin
    order_eff = order_log2;
    if (order_eff < mdsd_pkg::ORDER_MIN) order_eff = mdsd_pkg::ORDER_MIN;
    if (order_eff > MAX_ORDER) order_eff = MAX_ORDER;
    point_count = mdsd_pkg::count_t'(1) << order_eff;
    sel = mdsd_pkg::CONST_PAM2;
    if (order_eff != mdsd_pkg::ORDER_MIN) begin
      case (modulation)
        mdsd_pkg::FAM_PAM: begin
          if (order_eff == mdsd_pkg::ORDER_4PT) sel = mdsd_pkg::CONST_PAM4;
          else if (order_eff == mdsd_pkg::ORDER_8PT) sel = mdsd_pkg::CONST_PAM8;
          else sel = mdsd_pkg::CONST_PAM16;
        end
        mdsd_pkg::FAM_PSK: begin
          if (order_eff == mdsd_pkg::ORDER_4PT) sel = mdsd_pkg::CONST_PSK4;
          else if (order_eff == mdsd_pkg::ORDER_8PT) sel = mdsd_pkg::CONST_PSK8;
          else sel = mdsd_pkg::CONST_PSK16;
        end
        default: begin
          if (order_eff == mdsd_pkg::ORDER_4PT) sel = mdsd_pkg::CONST_PSK4;
          else if (order_eff == mdsd_pkg::ORDER_8PT) sel = mdsd_pkg::CONST_QAM8;
          else sel = mdsd_pkg::CONST_QAM16;
        end
      endcase
    end
  end

  assign out_load  = !out_valid || !out_stall;
  assign dist_load = !dist_valid || out_load;
  assign in_load   = !in_reg_valid || dist_load;
  assign in_stall  = !in_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_reg_valid <= 1'b0;
    end else if (in_load) begin
      in_reg_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_load && in_valid) begin
      in_reg <= in_data;
    end
  end

  // squared distance to every point, unused points pushed to full scale
  always_comb begin
    mdsd_pkg::point_t  p;
    mdsd_pkg::diff_t   dx;
    mdsd_pkg::diff_t   dy;
    mdsd_pkg::mag_t    mx;
    mdsd_pkg::mag_t    my;
    mdsd_pkg::square_t sx;
    mdsd_pkg::square_t sy;
    for (int n = 0; n < LANES; n++) begin
      p  = mdsd_pkg::CONSTELLATION_ROM[sel][n];
      dx = mdsd_pkg::diff_t'(in_reg.rx_inphase) - mdsd_pkg::diff_t'(p.i);
      dy = mdsd_pkg::diff_t'(in_reg.rx_quadrature) - mdsd_pkg::diff_t'(p.q);
      mx = dx[mdsd_pkg::DIFF_WIDTH-1] ? mdsd_pkg::mag_t'(-dx) : mdsd_pkg::mag_t'(dx);
      my = dy[mdsd_pkg::DIFF_WIDTH-1] ? mdsd_pkg::mag_t'(-dy) : mdsd_pkg::mag_t'(dy);
      sx = mx * mx;
      sy = my * my;
      if (mdsd_pkg::count_t'(n) < point_count) begin
        sq_dist_next[n] = mdsd_pkg::dist_t'(sx) + mdsd_pkg::dist_t'(sy);
      end else begin
        sq_dist_next[n] = '1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dist_valid <= 1'b0;
    end else if (dist_load) begin
      dist_valid <= in_reg_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (dist_load && in_reg_valid) begin
      sq_dist   <= sq_dist_next;
      dist_sent <= in_reg.sent_symbol;
    end
  end

  // min tree, left child holds the lower indices so ties keep the lower one
  always_comb begin
    for (int n = 0; n < LANES; n++) begin
      node_d[LANES-1+n] = sq_dist[n];
      node_i[LANES-1+n] = mdsd_pkg::symbol_t'(n);
    end
    for (int k = LANES - 2; k >= 0; k--) begin
      if (node_d[2*k+2] < node_d[2*k+1]) begin
        node_d[k] = node_d[2*k+2];
        node_i[k] = node_i[2*k+2];
      end else begin
        node_d[k] = node_d[2*k+1];
        node_i[k] = node_i[2*k+1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= dist_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load && dist_valid) begin
      out_data.decided_symbol <= node_i[0];
      out_data.symbol_error   <= (node_i[0] != dist_sent);
    end
  end

endmodule

// File: src/mdsd_checker.sv
`include "min_distance_symbol_detector_unit_macros.svh"

module mdsd_checker (
  input logic                clk,
  input logic                rst,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input mdsd_pkg::out_word_t out_data
);

  `MDSD_ASSERT_RUN(a_out_hold,
    out_valid && out_stall |=> out_valid && $stable(out_data),
    "output word changed while stalled")
  `MDSD_ASSERT_RUN(a_stall_full,
    in_stall |-> out_valid && out_stall,
    "input stalled while output free")
  `MDSD_ASSERT_ALWAYS(a_reset_empty,
    $past(rst) |-> !out_valid,
    "output valid right after reset")

endmodule

bind min_distance_symbol_detector_unit mdsd_checker u_mdsd_checker (.*);
